// File: sv/sequential_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Sequential list engine assertion macros
// Concurrent checks clocked on clk; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// check that is off while rst is high
`define SLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds through reset
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLE_ASSERT(lbl, prop, msg)
`define SLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants, codes and types of the sequential list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sle_pkg;

  localparam int DEPTH   = 128;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // item field widths
  localparam int REQ_W   = 3;
  localparam int POS_W   = 7;
  localparam int STAT_W  = 2;
  localparam int FIDX_W  = 7;
  localparam int COUNT_W = 8;

  // find scan: match bits examined one group per cycle
  localparam int GRP     = 16;
  localparam int GRP_W   = $clog2(GRP);
  localparam int NGRP    = (DEPTH + GRP - 1) / GRP;
  localparam int GSEL_W  = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_INSERT    = 3'd1,
    REQ_REMOVE    = 3'd2,
    REQ_OVERWRITE = 3'd3,
    REQ_FIND      = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_APPEND,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_WRITE,
    CMD_FIND
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    cell_cmd_t                 cmd;
    logic [IDX_W-1:0]          pos;
    logic [CNT_W-1:0]          cnt;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] index;
  } scan_res_t;

endpackage

// File: sv/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// One list entry: loads, shifts from a neighbor, or compares against a key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_cell (
  input  logic                              clk,
  input  sle_pkg::cell_ctl_t                ctl,
  input  logic [sle_pkg::IDX_W-1:0]         idx,
  input  logic signed [sle_pkg::DATA_W-1:0] left,
  input  logic signed [sle_pkg::DATA_W-1:0] right,
  output logic signed [sle_pkg::DATA_W-1:0] data,
  output logic                              match
);

  logic [sle_pkg::CNT_W-1:0] idx_c;

  assign idx_c = sle_pkg::CNT_W'(idx);

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      sle_pkg::CMD_APPEND: begin
        if (idx_c == ctl.cnt) data <= ctl.value;
      end
      sle_pkg::CMD_INSERT: begin
        if (idx == ctl.pos) data <= ctl.value;
        else if (idx > ctl.pos) data <= left;
      end
      sle_pkg::CMD_REMOVE: begin
        if (idx >= ctl.pos) data <= right;
      end
      sle_pkg::CMD_WRITE: begin
        if (idx == ctl.pos) data <= ctl.value;
      end
      sle_pkg::CMD_FIND: begin
        match <= (data == ctl.value) && (idx_c < ctl.cnt);
      end
      default: ;
    endcase
  end

endmodule

// File: sv/sle_scan.sv
// ----------------------------------------------------------------------------
// sle_scan
// Lowest-set-bit search over the cell match bits, one group per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       run,
  input  logic [sle_pkg::DEPTH-1:0]  match_vec,
  output sle_pkg::scan_res_t         res
);

  logic [sle_pkg::GSEL_W-1:0]            grp;
  logic [sle_pkg::NGRP*sle_pkg::GRP-1:0] mpad;
  logic [sle_pkg::GRP-1:0]               slice;
  logic [sle_pkg::GRP_W-1:0]             pe;

  always_ff @(posedge clk) begin
    if (rst || !run) begin
      grp <= '0;
    end else if (!res.done) begin
      grp <= grp + 1'b1;
    end
  end

  always_comb begin
    mpad = '0;
    mpad[sle_pkg::DEPTH-1:0] = match_vec;
    slice = mpad[int'(grp) * sle_pkg::GRP +: sle_pkg::GRP];
    pe = '0;
    for (int i = sle_pkg::GRP - 1; i >= 0; i--) begin
      if (slice[i]) pe = sle_pkg::GRP_W'(i);
    end
    res.hit   = |slice;
    res.done  = res.hit || (grp == sle_pkg::GSEL_W'(sle_pkg::NGRP - 1));
    res.index = sle_pkg::IDX_W'({grp, pe});
  end

endmodule

// File: sv/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed 32-bit values in a row of cells with an entry count.
// ----------------------------------------------------------------------------
// channel | handshake          | payload
// --------+--------------------+---------------------------------------------
// in      | in_valid/in_ready  | req_type, position, value
// out     | out_valid/out_ready| status, found, found_index, count,
//         |                    | is_empty, is_full
//
// Append, insert, remove, overwrite: cells update at the accept edge, then
// the emit state loads the output register. Find: cells latch match bits at
// the accept edge; the scan unit then checks 16 match bits per cycle.
// Only idle takes an item; a stalled result holds in the output register
// while the next item is taken, then the block stalls.
// Reset clears the count and control; entry contents are left as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sequential_list_engine_assert.svh"

module sequential_list_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sle_pkg::REQ_W-1:0]           req_type,
  input  logic [sle_pkg::POS_W-1:0]           position,
  input  logic signed [sle_pkg::DATA_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sle_pkg::STAT_W-1:0]          status,
  output logic                                found,
  output logic [sle_pkg::FIDX_W-1:0]          found_index,
  output logic [sle_pkg::COUNT_W-1:0]         count,
  output logic                                is_empty,
  output logic                                is_full
);

  localparam logic [sle_pkg::CNT_W-1:0] DEPTH_C = sle_pkg::CNT_W'(sle_pkg::DEPTH);

  sle_pkg::state_t    state, state_next;
  sle_pkg::cell_ctl_t ctl;
  sle_pkg::scan_res_t sres;
  sle_pkg::status_t   res_status, stat_next;

  logic [sle_pkg::CNT_W-1:0]  cnt, cnt_next;
  logic                       res_found;
  logic [sle_pkg::IDX_W-1:0]  res_idx;
  logic                       acc, full, badpos, load_out, scan_run;
  logic [sle_pkg::DEPTH-1:0]  match_vec;
  logic signed [sle_pkg::DATA_W-1:0] cell_data [sle_pkg::DEPTH];

  // cell chain
  for (genvar i = 0; i < sle_pkg::DEPTH; i++) begin : g_cell
    logic signed [sle_pkg::DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == sle_pkg::DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    sle_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (sle_pkg::IDX_W'(i)),
      .left  (left),
      .right (right),
      .data  (cell_data[i]),
      .match (match_vec[i])
    );
  end

  sle_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .run       (scan_run),
    .match_vec (match_vec),
    .res       (sres)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= sle_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign full   = (cnt == DEPTH_C);
  assign badpos = (sle_pkg::CNT_W'(position) >= cnt);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    scan_run   = 1'b0;
    acc        = 1'b0;
    cnt_next   = cnt;
    stat_next  = sle_pkg::STAT_DONE;
    ctl.cmd    = sle_pkg::CMD_IDLE;
    ctl.pos    = sle_pkg::IDX_W'(position);
    ctl.cnt    = cnt;
    ctl.value  = value;
    unique case (state)
      sle_pkg::S_IDLE: begin
        in_ready = 1'b1;
        acc      = in_valid;
        if (in_valid) begin
          state_next = sle_pkg::S_EMIT;
          unique case (req_type)
            sle_pkg::REQ_APPEND: begin
              if (full) begin
                stat_next = sle_pkg::STAT_FULL;
              end else begin
                ctl.cmd  = sle_pkg::CMD_APPEND;
                cnt_next = cnt + 1'b1;
              end
            end
            sle_pkg::REQ_INSERT: begin
              if (badpos) begin
                stat_next = sle_pkg::STAT_BADPOS;
              end else if (full) begin
                stat_next = sle_pkg::STAT_FULL;
              end else begin
                ctl.cmd  = sle_pkg::CMD_INSERT;
                cnt_next = cnt + 1'b1;
              end
            end
            sle_pkg::REQ_REMOVE: begin
              if (badpos) begin
                stat_next = sle_pkg::STAT_BADPOS;
              end else begin
                ctl.cmd  = sle_pkg::CMD_REMOVE;
                cnt_next = cnt - 1'b1;
              end
            end
            sle_pkg::REQ_OVERWRITE: begin
              if (badpos) stat_next = sle_pkg::STAT_BADPOS;
              else        ctl.cmd   = sle_pkg::CMD_WRITE;
            end
            sle_pkg::REQ_FIND: begin
              ctl.cmd    = sle_pkg::CMD_FIND;
              state_next = sle_pkg::S_SCAN;
            end
            default: ;
          endcase
        end
      end
      sle_pkg::S_SCAN: begin
        scan_run = 1'b1;
        if (sres.done) state_next = sle_pkg::S_EMIT;
      end
      sle_pkg::S_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = sle_pkg::S_IDLE;
        end
      end
      default: state_next = sle_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_status <= stat_next;
      res_found  <= 1'b0;
      res_idx    <= '0;
    end else if (scan_run && sres.done) begin
      res_found <= sres.hit;
      res_idx   <= sres.hit ? sres.index : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res_status;
      found       <= res_found;
      found_index <= sle_pkg::FIDX_W'(res_idx);
      count       <= sle_pkg::COUNT_W'(cnt);
      is_empty    <= (cnt == '0);
      is_full     <= (cnt == DEPTH_C);
    end
  end

  `SLE_ASSERT(a_cnt_range, cnt <= DEPTH_C, "entry count above depth")
  `SLE_ASSERT(a_busy_after_acc, acc |=> (state != sle_pkg::S_IDLE), "idle after accept")
  `SLE_ASSERT(a_cnt_hold, (!$past(rst) && !$past(acc)) |-> $stable(cnt), "count moved")
  `SLE_ASSERT(a_found_done, (out_valid && found) |-> (status == sle_pkg::STAT_DONE), "bad hit")

endmodule

// File: tb/sv/sequential_list_engine_tb.sv
// ----------------------------------------------------------------------------
// sequential_list_engine_tb
// Self-checking bench for the sequential list engine. A behavioral list
// model predicts every reply as each item is accepted; replies are checked
// in order, field by field. Directed corner cases come first, then a
// fill/drain pass, biased random traffic, a long output stall and a run
// with no idle cycles on either side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sequential_list_engine_tb;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int MAX_PRINTED    = 20;

  localparam logic [sle_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [sle_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam logic signed [sle_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [sle_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [sle_pkg::STAT_W-1:0]  status;
    logic                        found;
    logic [sle_pkg::FIDX_W-1:0]  found_index;
    logic [sle_pkg::COUNT_W-1:0] count;
    logic                        is_empty;
    logic                        is_full;
  } list_reply_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [sle_pkg::REQ_W-1:0]         req_type = '0;
  logic [sle_pkg::POS_W-1:0]         position = '0;
  logic signed [sle_pkg::DATA_W-1:0] value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [sle_pkg::STAT_W-1:0]        status;
  logic                              found;
  logic [sle_pkg::FIDX_W-1:0]        found_index;
  logic [sle_pkg::COUNT_W-1:0]       count;
  logic                              is_empty;
  logic                              is_full;

  // list model
  logic signed [sle_pkg::DATA_W-1:0] list_vals [sle_pkg::DEPTH];
  int                                list_len = 0;
  list_reply_t                       replies_due [$];

  // traffic shaping
  bit src_idle_on   = 1'b1;
  bit sink_idle_on  = 1'b1;
  int holdoff_reqs  = 0;
  int grow_pct      = 50;

  // bookkeeping
  int          error_count = 0;
  int          replies_checked = 0;
  int          sent_by_code [8];
  int          full_refusals = 0;
  int          badpos_refusals = 0;
  int          find_hits = 0;
  int          peak_len = 0;
  int unsigned cycle_count = 0;

  sequential_list_engine dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .found      (found),
    .found_index(found_index),
    .count      (count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               replies_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Applies one request to the list model and returns the reply it gives.
  function automatic list_reply_t apply_list_request(
      logic [sle_pkg::REQ_W-1:0] code, logic [sle_pkg::POS_W-1:0] pos,
      logic signed [sle_pkg::DATA_W-1:0] val);
    list_reply_t r;
    bit          was_full;
    int          i;
    r = '0;
    r.status = sle_pkg::STAT_DONE;
    was_full = (list_len >= sle_pkg::DEPTH);
    sent_by_code[code]++;
    case (code)
      sle_pkg::REQ_APPEND: begin
        if (was_full) begin
          r.status = sle_pkg::STAT_FULL;
        end else begin
          list_vals[list_len] = val;
          list_len++;
        end
      end
      sle_pkg::REQ_INSERT: begin
        // position check wins over the full check
        if (pos >= list_len) begin
          r.status = sle_pkg::STAT_BADPOS;
        end else if (was_full) begin
          r.status = sle_pkg::STAT_FULL;
        end else begin
          for (i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = val;
          list_len++;
        end
      end
      sle_pkg::REQ_REMOVE: begin
        if (pos >= list_len) begin
          r.status = sle_pkg::STAT_BADPOS;
        end else begin
          list_len--;
          for (i = pos; i < list_len; i++) list_vals[i] = list_vals[i+1];
        end
      end
      sle_pkg::REQ_OVERWRITE: begin
        if (pos >= list_len) r.status = sle_pkg::STAT_BADPOS;
        else list_vals[pos] = val;
      end
      sle_pkg::REQ_FIND: begin
        for (i = 0; i < list_len; i++) begin
          if (!r.found && list_vals[i] == val) begin
            r.found = 1'b1;
            r.found_index = sle_pkg::FIDX_W'(i);
          end
        end
        if (r.found) find_hits++;
      end
      default: ;
    endcase
    if (r.status == sle_pkg::STAT_FULL) full_refusals++;
    if (r.status == sle_pkg::STAT_BADPOS) badpos_refusals++;
    if (list_len > peak_len) peak_len = list_len;
    r.count    = sle_pkg::COUNT_W'(list_len);
    r.is_empty = (list_len == 0);
    r.is_full  = (list_len == sle_pkg::DEPTH);
    return r;
  endfunction

  function automatic logic signed [sle_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      4, 5, 6: return $urandom_range(16) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string text);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, text);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("reply %0d %s got %0h expected %0h",
                                replies_checked, name, got, want));
  endtask

  // Drives one item and waits for it to be taken; valid stays high on return.
  task automatic send_request(input logic [sle_pkg::REQ_W-1:0] code,
                              input logic [sle_pkg::POS_W-1:0] pos,
                              input logic signed [sle_pkg::DATA_W-1:0] val);
    if (src_idle_on) begin
      while ($urandom_range(99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    req_type <= code;
    position <= pos;
    value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    replies_due.push_back(apply_list_request(code, pos, val));
  endtask

  // Sender goes quiet until every predicted reply has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    logic [sle_pkg::REQ_W-1:0]         code;
    logic [sle_pkg::POS_W-1:0]         pos;
    logic signed [sle_pkg::DATA_W-1:0] val;
    int                                roll;
    roll = $urandom_range(99);
    if (roll < 3)
      code = sle_pkg::REQ_W'(REQ_SPARE_LO + $urandom_range(REQ_SPARE_HI - REQ_SPARE_LO));
    else if (roll < 25) code = sle_pkg::REQ_FIND;
    else if (roll < 37) code = sle_pkg::REQ_OVERWRITE;
    else if ($urandom_range(99) < grow_pct)
      code = ($urandom_range(1) != 0) ? sle_pkg::REQ_INSERT : sle_pkg::REQ_APPEND;
    else code = sle_pkg::REQ_REMOVE;
    // mostly in-range positions, sometimes exactly the count, sometimes anything
    roll = $urandom_range(9);
    if (list_len != 0 && roll < 8)
      pos = sle_pkg::POS_W'($urandom_range(list_len - 1));
    else if (roll == 8 && list_len < sle_pkg::DEPTH)
      pos = sle_pkg::POS_W'(list_len);
    else
      pos = sle_pkg::POS_W'($urandom_range(2**sle_pkg::POS_W - 1));
    if (code == sle_pkg::REQ_FIND && list_len != 0 && $urandom_range(9) < 6)
      val = list_vals[$urandom_range(list_len - 1)];
    else val = pick_value();
    send_request(code, pos, val);
  endtask

  task automatic test_directed();
    logic [sle_pkg::REQ_W-1:0] code;
    // empty list
    send_request(sle_pkg::REQ_FIND, '0, '0);
    send_request(sle_pkg::REQ_REMOVE, '0, '0);
    send_request(sle_pkg::REQ_OVERWRITE, '0, 32'sd9);
    send_request(sle_pkg::REQ_INSERT, '0, 32'sd9);
    // build min, max, -1 then insert at the front and before the tail
    send_request(sle_pkg::REQ_APPEND, '0, VAL_MIN);
    send_request(sle_pkg::REQ_APPEND, '0, VAL_MAX);
    send_request(sle_pkg::REQ_APPEND, '0, -1);
    send_request(sle_pkg::REQ_INSERT, 7'd0, '0);
    send_request(sle_pkg::REQ_INSERT, 7'd3, 32'sd5);
    // insert at the count and far past it are refused
    send_request(sle_pkg::REQ_INSERT, 7'd5, 32'sd7);
    send_request(sle_pkg::REQ_INSERT, 7'd127, 32'sd7);
    // duplicate -1 so find must report the lowest position
    send_request(sle_pkg::REQ_OVERWRITE, 7'd1, -1);
    send_request(sle_pkg::REQ_FIND, '0, -1);
    send_request(sle_pkg::REQ_FIND, '0, VAL_MAX);
    send_request(sle_pkg::REQ_FIND, '0, VAL_MIN);
    send_request(sle_pkg::REQ_OVERWRITE, 7'd127, '0);
    send_request(sle_pkg::REQ_REMOVE, 7'd127, '0);
    send_request(sle_pkg::REQ_REMOVE, 7'd4, '0);
    send_request(sle_pkg::REQ_REMOVE, 7'd0, '0);
    for (code = REQ_SPARE_LO; code <= REQ_SPARE_HI && code >= REQ_SPARE_LO; code++)
      send_request(code, 7'd127, -1);
    send_request(sle_pkg::REQ_FIND, 7'd127, 32'sd5);
    while (list_len != 0) send_request(sle_pkg::REQ_REMOVE, '0, '0);
  endtask

  task automatic test_fill_and_drain();
    while (list_len < sle_pkg::DEPTH) begin
      if (list_len != 0 && $urandom_range(1) != 0)
        send_request(sle_pkg::REQ_INSERT, sle_pkg::POS_W'($urandom_range(list_len - 1)),
                     pick_value());
      else
        send_request(sle_pkg::REQ_APPEND,
                     sle_pkg::POS_W'($urandom_range(2**sle_pkg::POS_W - 1)), pick_value());
    end
    // refusals on a full list, then overwrite and find at the tail, remove and refill
    send_request(sle_pkg::REQ_APPEND, '0, 32'sd1);
    send_request(sle_pkg::REQ_INSERT, 7'd0, 32'sd1);
    send_request(sle_pkg::REQ_INSERT, 7'd127, 32'sd1);
    send_request(sle_pkg::REQ_OVERWRITE, 7'd127, 32'sh7fff_fffe);
    send_request(sle_pkg::REQ_FIND, '0, 32'sh7fff_fffe);
    send_request(sle_pkg::REQ_REMOVE, 7'd127, '0);
    send_request(sle_pkg::REQ_APPEND, '0, 32'sh7fff_fffe);
    while (list_len != 0)
      send_request(sle_pkg::REQ_REMOVE, sle_pkg::POS_W'($urandom_range(list_len - 1)), '0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int k;
    for (k = 0; k < n_items; k++) begin
      // sweep the fill level by changing the growth bias now and then
      if (k % 100 == 0) grow_pct = $urandom_range(25, 75);
      send_random_request();
    end
    grow_pct = 50;
  endtask

  task automatic test_output_stall();
    int k;
    holdoff_reqs++;
    for (k = 0; k < 40; k++) send_random_request();
    wait_for_drain();
    for (k = 0; k < 20; k++) send_random_request();
  endtask

  task automatic test_back_to_back();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_traffic(150);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // result side: random stalls plus an occasional long hold-off
  initial begin : reply_sink
    int hold_left;
    int holdoffs_taken;
    hold_left = 0;
    holdoffs_taken = 0;
    forever begin
      @(posedge clk);
      if (holdoff_reqs != holdoffs_taken) begin
        holdoffs_taken = holdoff_reqs;
        hold_left = HOLDOFF_CYCLES;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (sink_idle_on && $urandom_range(99) < 9) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : reply_check
    list_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("reply with nothing pending (status %0h count %0d)",
                                  status, count));
      end else begin
        want = replies_due.pop_front();
        check_field("status", 32'(status), 32'(want.status));
        check_field("found", 32'(found), 32'(want.found));
        check_field("found_index", 32'(found_index), 32'(want.found_index));
        check_field("count", 32'(count), 32'(want.count));
        check_field("is_empty", 32'(is_empty), 32'(want.is_empty));
        check_field("is_full", 32'(is_full), 32'(want.is_full));
      end
      replies_checked++;
    end
  end

  initial begin : main_seq
    int spare_sent;
    int c;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_drain();
    test_random_traffic(800);
    test_output_stall();
    test_back_to_back();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    spare_sent = 0;
    for (c = int'(REQ_SPARE_LO); c <= int'(REQ_SPARE_HI); c++) spare_sent += sent_by_code[c];
    $display("covered %0d replies: append %0d insert %0d remove %0d overwrite %0d",
             replies_checked, sent_by_code[sle_pkg::REQ_APPEND],
             sent_by_code[sle_pkg::REQ_INSERT], sent_by_code[sle_pkg::REQ_REMOVE],
             sent_by_code[sle_pkg::REQ_OVERWRITE]);
    $display("find %0d spare %0d; list peaked at %0d, %0d full, %0d bad pos, %0d hits",
             sent_by_code[sle_pkg::REQ_FIND], spare_sent, peak_len, full_refusals,
             badpos_refusals, find_hits);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", error_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
